FILE: sv/kwt_pkg.sv
// ============================================================================
// kwt_pkg: shared types and constants of the keyword tokenizer
// Token codes, character classes, the keyword table and the word that
// passes between the front end, the token queue and the output stage.
// ============================================================================
package kwt_pkg;

   localparam int POS_WIDTH   = 24;
   localparam int KW_MAX_LEN  = 7;
   localparam int KW_IDX_W    = $clog2(KW_MAX_LEN);
   localparam int KW_COUNT    = 16;
   localparam int KW_TEXT_LEN = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   typedef logic [7:0]           byte_type;
   typedef logic [4:0]           kind_type;
   typedef logic [POS_WIDTH-1:0] pos_type;
   typedef byte_type             word_type [KW_MAX_LEN];

   // Token kinds.
   localparam kind_type KIND_INTEGER = 5'd0;
   localparam kind_type KIND_NONE    = 5'd1;  // never emitted; marks "not punctuation"
   localparam kind_type KIND_IF      = 5'd2;
   localparam kind_type KIND_ELSE    = 5'd3;
   localparam kind_type KIND_ELF     = 5'd4;
   localparam kind_type KIND_DO      = 5'd5;
   localparam kind_type KIND_FOR     = 5'd6;
   localparam kind_type KIND_WHILE   = 5'd7;
   localparam kind_type KIND_BOOL    = 5'd8;
   localparam kind_type KIND_TRUE    = 5'd9;
   localparam kind_type KIND_FALSE   = 5'd10;
   localparam kind_type KIND_INT     = 5'd11;
   localparam kind_type KIND_FLOAT   = 5'd12;
   localparam kind_type KIND_DOUBLE  = 5'd13;
   localparam kind_type KIND_CHAR    = 5'd14;
   localparam kind_type KIND_STRING  = 5'd15;
   localparam kind_type KIND_STR     = 5'd16;
   localparam kind_type KIND_PLUS    = 5'd17;
   localparam kind_type KIND_MINUS   = 5'd18;
   localparam kind_type KIND_STAR    = 5'd19;
   localparam kind_type KIND_SLASH   = 5'd20;
   localparam kind_type KIND_QUOTE   = 5'd21;
   localparam kind_type KIND_LPAREN  = 5'd22;
   localparam kind_type KIND_RPAREN  = 5'd23;
   localparam kind_type KIND_LBRACE  = 5'd24;
   localparam kind_type KIND_RBRACE  = 5'd25;
   localparam kind_type KIND_LBRACK  = 5'd26;
   localparam kind_type KIND_RBRACK  = 5'd27;
   localparam kind_type KIND_SEMI    = 5'd28;
   localparam kind_type KIND_END     = 5'd29;
   localparam kind_type KIND_IDENT   = 5'd30;
   localparam kind_type KIND_ERROR   = 5'd31;

   // Character codes.
   localparam byte_type CH_TAB     = 8'h09;
   localparam byte_type CH_CR      = 8'h0D;
   localparam byte_type CH_SPACE   = 8'h20;
   localparam byte_type CH_QUOTE   = 8'h22;
   localparam byte_type CH_LPAREN  = 8'h28;
   localparam byte_type CH_RPAREN  = 8'h29;
   localparam byte_type CH_STAR    = 8'h2A;
   localparam byte_type CH_PLUS    = 8'h2B;
   localparam byte_type CH_MINUS   = 8'h2D;
   localparam byte_type CH_SLASH   = 8'h2F;
   localparam byte_type CH_DIGIT_0 = 8'h30;
   localparam byte_type CH_DIGIT_9 = 8'h39;
   localparam byte_type CH_SEMI    = 8'h3B;
   localparam byte_type CH_UPPER_A = 8'h41;
   localparam byte_type CH_UPPER_Z = 8'h5A;
   localparam byte_type CH_LBRACK  = 8'h5B;
   localparam byte_type CH_RBRACK  = 8'h5D;
   localparam byte_type CH_LOWER_A = 8'h61;
   localparam byte_type CH_LOWER_Z = 8'h7A;
   localparam byte_type CH_LBRACE  = 8'h7B;
   localparam byte_type CH_RBRACE  = 8'h7D;
   localparam byte_type CASE_BIT   = 8'h20;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_WORD,
      RUN_DIGIT
   } run_kind_type;

   typedef struct packed {
      kind_type kind;
      pos_type  start;
      pos_type  length;
      byte_type bad;
      logic     last;
   } token_type;

   // Up to two tokens pushed by the front end in one cycle, first in order first.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   // Head of the token queue as seen by the output stage.
   typedef struct packed {
      logic      valid;
      token_type tok;
   } head_type;

   function automatic kind_type punct_kind(input byte_type c);
      kind_type k;
      unique case (c)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_SLASH:  k = KIND_SLASH;
         CH_QUOTE:  k = KIND_QUOTE;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LBRACE: k = KIND_LBRACE;
         CH_RBRACE: k = KIND_RBRACE;
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         CH_SEMI:   k = KIND_SEMI;
         default:   k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Keyword text, right-justified: the first character sits highest.
   function automatic logic [8*KW_TEXT_LEN-1:0] kw_text(input int idx);
      logic [8*KW_TEXT_LEN-1:0] t;
      unique case (idx)
         0:       t = "if";
         1:       t = "else";
         2:       t = "elf";
         3:       t = "do";
         4:       t = "while";
         5:       t = "for";
         6:       t = "true";
         7:       t = "false";
         8:       t = "int";
         9:       t = "bool";
         10:      t = "boolean";
         11:      t = "char";
         12:      t = "str";
         13:      t = "string";
         14:      t = "float";
         default: t = "double";
      endcase
      return t;
   endfunction

   function automatic int kw_len(input int idx);
      int n;
      unique case (idx)
         0, 3:              n = 2;
         2, 5, 8, 12:       n = 3;
         1, 6, 9, 11:       n = 4;
         4, 7, 14:          n = 5;
         13, 15:            n = 6;
         default:           n = 7;
      endcase
      return n;
   endfunction

   function automatic kind_type kw_kind(input int idx);
      kind_type k;
      unique case (idx)
         0:       k = KIND_IF;
         1:       k = KIND_ELSE;
         2:       k = KIND_ELF;
         3:       k = KIND_DO;
         4:       k = KIND_WHILE;
         5:       k = KIND_FOR;
         6:       k = KIND_TRUE;
         7:       k = KIND_FALSE;
         8:       k = KIND_INT;
         9:       k = KIND_BOOL;
         10:      k = KIND_BOOL;
         11:      k = KIND_CHAR;
         12:      k = KIND_STR;
         13:      k = KIND_STRING;
         14:      k = KIND_FLOAT;
         default: k = KIND_DOUBLE;
      endcase
      return k;
   endfunction

   // Classifies a finished letter run. Keywords are distinct, so the
   // sixteen comparisons are independent and at most one can hit.
   function automatic kind_type word_kind(input word_type wbuf, input pos_type count);
      kind_type                 res;
      logic                     hit;
      logic [8*KW_TEXT_LEN-1:0] txt;
      int                       len;
      res = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         txt = kw_text(i);
         len = kw_len(i);
         hit = (count == POS_WIDTH'(len));
         for (int j = 0; j < KW_TEXT_LEN; j++) begin
            if (j < len) begin
               hit = hit && (wbuf[j] == txt[8*(len-1-j) +: 8]);
            end
         end
         if (hit) begin
            res = kw_kind(i);
         end
      end
      return res;
   endfunction

endpackage

FILE: sv/kwt_req_if.sv
// ============================================================================
// kwt_req_if: source byte channel
// Carries one source byte or the end-of-source mark per word.
// ============================================================================
interface kwt_req_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           ch;
   logic                 end_of_source;

   modport source (output valid, output ch, output end_of_source, input ready);
   modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

FILE: sv/kwt_rsp_if.sv
// ============================================================================
// kwt_rsp_if: token channel
// Carries one token per word: kind, position, length, error byte, last flag.
// ============================================================================
interface kwt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [4:0]                    token_kind;
   logic [kwt_pkg::POS_WIDTH-1:0] start_pos;
   logic [kwt_pkg::POS_WIDTH-1:0] run_length;
   logic [7:0]                    bad_char;
   logic                          last;

   modport source (output valid, output token_kind, output start_pos, output run_length,
                   output bad_char, output last, input ready);
   modport sink   (input valid, input token_kind, input start_pos, input run_length,
                   input bad_char, input last, output ready);
endinterface

FILE: sv/kwt_front.sv
// ============================================================================
// kwt_front: byte classifier and run tracker
// Classifies each accepted byte, tracks the open run and pushes the tokens
// the byte causes (zero, one or two) into the token queue.
// ============================================================================
module kwt_front (
   input  logic              clock,
   input  logic              reset,
   kwt_req_if.sink           req_port,
   input  logic              space_ok,
   output kwt_pkg::push_type push
);
   import kwt_pkg::*;

   run_kind_type run_kind_ff, run_kind_in;
   pos_type      run_count_ff, run_count_in;
   pos_type      run_start_ff, run_start_in;
   pos_type      pos_ff, pos_in;
   logic         halted_ff, halted_in;
   word_type     word_ff;

   logic         accept;
   byte_type     c;
   logic         is_letter, is_digit, is_space;
   kind_type     pk;
   run_kind_type want, cur_kind;
   logic         do_flush;
   pos_type      cnt;
   token_type    run_tok, byte_tok;
   logic         byte_tok_valid;
   logic         wr_en;
   logic [KW_IDX_W-1:0] wr_idx;
   byte_type     wr_data;

   assign req_port.ready = space_ok;
   assign accept = req_port.valid && space_ok;
   assign c      = req_port.ch;

   always_comb begin
      is_letter = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
                  ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
      is_digit  = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
      is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      pk        = punct_kind(c);
      priority if (is_letter) begin
         want = RUN_WORD;
      end else if (is_digit) begin
         want = RUN_DIGIT;
      end else begin
         want = RUN_NONE;
      end
   end

   always_comb begin
      run_tok.kind   = (run_kind_ff == RUN_DIGIT) ? KIND_INTEGER
                                                  : word_kind(word_ff, run_count_ff);
      run_tok.start  = run_start_ff;
      run_tok.length = run_count_ff;
      run_tok.bad    = '0;
      run_tok.last   = 1'b0;
   end

   always_comb begin
      run_kind_in    = run_kind_ff;
      run_count_in   = run_count_ff;
      run_start_in   = run_start_ff;
      pos_in         = pos_ff;
      halted_in      = halted_ff;
      do_flush       = 1'b0;
      cur_kind       = run_kind_ff;
      cnt            = run_count_ff;
      byte_tok       = '0;
      byte_tok_valid = 1'b0;
      wr_en          = 1'b0;
      wr_idx         = '0;
      wr_data        = c;
      push           = '0;

      if (accept) begin
         if (req_port.end_of_source) begin
            byte_tok.kind  = KIND_END;
            byte_tok.start = pos_ff;
            byte_tok_valid = 1'b1;
            do_flush       = (run_kind_ff != RUN_NONE);
            run_kind_in    = RUN_NONE;
            run_count_in   = '0;
            run_start_in   = '0;
            pos_in         = '0;
            halted_in      = 1'b0;
         end else begin
            if (!halted_ff) begin
               do_flush = (run_kind_ff != RUN_NONE) &&
                          !((want != RUN_NONE) && (want == run_kind_ff));
               if (do_flush) begin
                  cur_kind = RUN_NONE;
                  cnt      = '0;
               end
               if (want != RUN_NONE) begin
                  if (cur_kind == RUN_NONE) begin
                     run_kind_in  = want;
                     run_start_in = pos_ff;
                  end else begin
                     run_kind_in  = cur_kind;
                  end
                  if ((want == RUN_WORD) && (cnt < POS_WIDTH'(KW_MAX_LEN))) begin
                     wr_en   = 1'b1;
                     wr_idx  = cnt[KW_IDX_W-1:0];
                     wr_data = (c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
                  end
                  run_count_in = (cnt < POS_MAX) ? cnt + 1'b1 : cnt;
               end else begin
                  run_kind_in  = RUN_NONE;
                  run_count_in = '0;
                  byte_tok.start  = pos_ff;
                  byte_tok.length = POS_WIDTH'(1);
                  if (pk != KIND_NONE) begin
                     byte_tok.kind  = pk;
                     byte_tok_valid = 1'b1;
                  end else if (!is_space) begin
                     byte_tok.kind  = KIND_ERROR;
                     byte_tok.bad   = c;
                     byte_tok_valid = 1'b1;
                     halted_in      = 1'b1;
                  end
               end
            end
            pos_in = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : pos_ff;
         end

         // Order the tokens and mark the final one of this byte.
         byte_tok.last = 1'b1;
         if (do_flush && byte_tok_valid) begin
            push.count  = 2'd2;
            push.first  = run_tok;
            push.second = byte_tok;
         end else if (do_flush) begin
            push.count      = 2'd1;
            push.first      = run_tok;
            push.first.last = 1'b1;
         end else if (byte_tok_valid) begin
            push.count = 2'd1;
            push.first = byte_tok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff  <= RUN_NONE;
         run_count_ff <= '0;
         run_start_ff <= '0;
         pos_ff       <= '0;
         halted_ff    <= 1'b0;
      end else begin
         run_kind_ff  <= run_kind_in;
         run_count_ff <= run_count_in;
         run_start_ff <= run_start_in;
         pos_ff       <= pos_in;
         halted_ff    <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_ff[wr_idx] <= wr_data;
      end
   end

endmodule

FILE: sv/kwt_queue.sv
// ============================================================================
// kwt_queue: token queue between front end and output stage
// Takes up to two tokens per cycle, gives one per cycle when popped, in order.
// ============================================================================
module kwt_queue (
   input  logic              clock,
   input  logic              reset,
   input  kwt_pkg::push_type push,
   input  logic              pop,
   output logic              space_ok,
   output kwt_pkg::head_type head
);
   import kwt_pkg::*;

   token_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic [QPTR_W-1:0]   wr_ptr_next;

   // Room for the worst case of two tokens from one byte.
   assign space_ok    = (count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
   assign head.valid  = (count_ff != '0);
   assign head.tok    = entry_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

FILE: sv/kwt_back.sv
// ============================================================================
// kwt_back: token output stage
// Registers the queue head onto the token channel and pops the queue.
// ============================================================================
module kwt_back (
   input  logic              clock,
   input  logic              reset,
   input  kwt_pkg::head_type head,
   output logic              pop,
   kwt_rsp_if.source         rsp_port
);
   import kwt_pkg::*;

   logic      valid_ff, valid_in;
   token_type tok_ff;

   assign pop      = head.valid && (!valid_ff || rsp_port.ready);
   assign valid_in = pop || (valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head.tok;
      end
   end

   assign rsp_port.valid      = valid_ff;
   assign rsp_port.token_kind = tok_ff.kind;
   assign rsp_port.start_pos  = tok_ff.start;
   assign rsp_port.run_length = tok_ff.length;
   assign rsp_port.bad_char   = tok_ff.bad;
   assign rsp_port.last       = tok_ff.last;

endmodule

FILE: sv/keyword_tokenizer_core.sv
// ============================================================================
// keyword_tokenizer_core: streaming lexical tokenizer with keyword lookup
// Turns a byte stream into integer, keyword, identifier, punctuation,
// error and end tokens, each with start offset and length.
// ============================================================================
// The core accepts one source byte per cycle while the queue has room and
// emits one token per cycle while the consumer is ready. A byte that closes
// a run and is itself punctuation or an error causes two tokens, as does the
// end-of-source mark when a run is open; such bytes are bounded by the
// single-word output stage, so the sustained input rate is one byte per
// cycle while bytes cause at most one token each and falls during stretches
// where every byte causes two. With the queue empty, the first token of an
// accepted byte is registered in the queue and then in the output register.
// A four-entry token queue sits between the classifier and the output
// register; the input is ready whenever the queue has room for two tokens,
// so a stalled output holds off the input only once the queue holds more
// than two tokens.
// Letter runs are matched case-insensitively against sixteen keywords on
// their first seven characters; longer runs are identifiers. After an error
// token the core drops bytes, still counting them, until end of source.
// Offsets and lengths saturate at the largest 24-bit value.
module keyword_tokenizer_core (
   input  logic      clock,
   input  logic      reset,
   kwt_req_if.sink   req_port,
   kwt_rsp_if.source rsp_port
);
   import kwt_pkg::*;

   push_type push;
   head_type head;
   logic     space_ok;
   logic     pop;

   // Front end: classifies each byte, tracks the open run and decides
   // which tokens the byte produces. It holds all run, position and halt state.
   kwt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .space_ok (space_ok),
      .push     (push)
   );

   // Token queue: absorbs the two-token bursts so the front end keeps
   // taking bytes while the output drains.
   kwt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .space_ok (space_ok),
      .head     (head)
   );

   // Output stage: one registered token word toward the consumer.
   kwt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule
